@@ src/assert_macros.svh @@
// Assertion macros shared by the frame builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define CFB_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/crc16cfb_pkg.sv @@
// Types, constants and CRC helper for the CRC-16 command frame builder.
package crc16cfb_pkg;

  localparam int FRAME_WORDS = 7;
  localparam int FRAME_BYTES = 14;
  localparam int CRC_WORDS   = 6;
  localparam int CRC_BITS    = CRC_WORDS * 16;
  localparam int CRC_STEPS   = CRC_BITS / 8;
  localparam int STEP_W      = $clog2(CRC_STEPS + 1);
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] OPCODE_RESET  = 16'h1103;
  localparam logic [15:0] TRAILER_RESET = 16'h4f4f;

  localparam logic [0:0] REG_OPCODE  = 1'b0;
  localparam logic [0:0] REG_TRAILER = 1'b1;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  typedef logic [FRAME_WORDS-1:0][15:0] frame_t;

  // Shift eight message bits into the CRC, most significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    logic        carry;
    crc = crc_in;
    for (int b = 7; b >= 0; b--) begin
      carry = crc[15];
      crc   = {crc[14:0], data[b]};
      if (carry) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

@@ src/crc16_command_frame_builder.sv @@
// CRC-16 command frame builder: top level joining front end, queue and sender.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one write command: node id,
//   object index and 32-bit value. Output channel (out_valid / out_stall)
//   returns 14 frame bytes in send order; out_last_byte marks the 14th.
//   cfg_we writes opcode_word (index 0) or trailer_word (index 1); the user
//   must do so only while idle, as the block itself does not enforce it.
// Timing:
//   The front end runs the CRC over 96 message bits at one byte per cycle
//   and takes a new command only once its frame is pushed to the queue. The
//   first byte then passes bytes_r and the output register; the sender puts
//   out one byte per cycle while out_stall is low and bounds the command rate.
//   A two-frame queue sits between CRC and sender; the front end keeps
//   taking commands while earlier frames are still being sent.
// Reset (rst_n low, synchronous) empties the pipe and restores the register
// defaults 0x1103 and 0x4f4f. When the receiver stalls, the current byte
// holds, the queue fills and then in_stall stays high with a frame waiting.
module crc16_command_frame_builder import crc16cfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_node_id,
  input  logic [15:0] in_object_index,
  input  logic [31:0] in_data_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte
);

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  frame_t q_wdata;
  frame_t q_rdata;

  crc16cfb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_node_id      (in_node_id),
    .in_object_index (in_object_index),
    .in_data_value   (in_data_value),
    .q_push          (q_push),
    .q_wdata         (q_wdata),
    .q_full          (q_full)
  );

  crc16cfb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  crc16cfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rdata        (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

@@ src/crc16cfb_front.sv @@
// Front end: config registers, command capture and byte-wide CRC over the frame.
`include "assert_macros.svh"
module crc16cfb_front import crc16cfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_node_id,
  input  logic [15:0] in_object_index,
  input  logic [31:0] in_data_value,
  output logic        q_push,
  output frame_t      q_wdata,
  input  logic        q_full
);

  logic [15:0]          opcode_r, opcode_nxt;
  logic [15:0]          trailer_r, trailer_nxt;
  logic                 busy_r, busy_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [CRC_BITS-1:0]  msg_r, msg_nxt;
  logic [15:0]          crc_r, crc_nxt;
  frame_t               words_r, words_nxt;
  logic                 done;
  logic                 accept;

  assign done     = (step_r == STEP_W'(CRC_STEPS));
  assign q_push   = busy_r && done && !q_full;
  assign in_stall = busy_r && !q_push;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    q_wdata    = words_r;
    q_wdata[5] = crc_r;
  end

  always_comb begin
    opcode_nxt  = opcode_r;
    trailer_nxt = trailer_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_OPCODE:  opcode_nxt  = cfg_wdata;
        REG_TRAILER: trailer_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    msg_nxt   = msg_r;
    crc_nxt   = crc_r;
    words_nxt = words_r;
    if (busy_r && !done) begin
      // one message byte per cycle
      crc_nxt  = crc_byte(crc_r, msg_r[CRC_BITS-1 -: 8]);
      msg_nxt  = {msg_r[CRC_BITS-9:0], 8'h00};
      step_nxt = step_r + STEP_W'(1);
    end
    if (q_push) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      words_nxt    = '0;
      words_nxt[0] = opcode_r;
      words_nxt[1] = in_object_index;
      words_nxt[2] = {in_node_id[7:0], in_node_id[15:8]};
      words_nxt[3] = in_data_value[15:0];
      words_nxt[4] = in_data_value[31:16];
      words_nxt[6] = trailer_r;
      // CRC slot counts as zero during the CRC
      msg_nxt  = {opcode_r, in_object_index, in_node_id[7:0], in_node_id[15:8],
                  in_data_value[15:0], in_data_value[31:16], 16'h0000};
      crc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_r  <= OPCODE_RESET;
      trailer_r <= TRAILER_RESET;
      busy_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      opcode_r  <= opcode_nxt;
      trailer_r <= trailer_nxt;
      busy_r    <= busy_nxt;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r   <= msg_nxt;
    crc_r   <= crc_nxt;
    words_r <= words_nxt;
  end

  `CFB_ASSERT_NXT(a_front_holds, busy_r && !done, busy_r, "front dropped an item mid-CRC")

endmodule

@@ src/crc16cfb_queue.sv @@
// Two-entry frame queue between the CRC front end and the byte sender.
`include "assert_macros.svh"
module crc16cfb_queue import crc16cfb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t wdata,
  output logic   full,
  input  logic   pop,
  output frame_t rdata,
  output logic   empty
);

  frame_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `CFB_ASSERT(a_no_overflow, !(push && full), "push into full frame queue")
  `CFB_ASSERT(a_no_underflow, !(pop && empty), "pop from empty frame queue")

endmodule

@@ src/crc16cfb_back.sv @@
// Back end: unpacks a frame into bytes and sends them through an output register.
`include "assert_macros.svh"
module crc16cfb_back import crc16cfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  frame_t     q_rdata,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  logic [7:0]       bytes_r [FRAME_BYTES];
  logic [7:0]       bytes_nxt [FRAME_BYTES];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;

  assign out_free       = !out_valid_r || !out_stall;
  assign q_pop          = !q_empty && (!busy_r || (out_free && pos_r == LAST_POS));
  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  // word 0 goes high byte first, the rest low byte first
  always_comb begin
    bytes_nxt = bytes_r;
    if (q_pop) begin
      bytes_nxt[0] = q_rdata[0][15:8];
      bytes_nxt[1] = q_rdata[0][7:0];
      for (int j = 1; j < FRAME_WORDS; j++) begin
        bytes_nxt[2*j]   = q_rdata[j][7:0];
        bytes_nxt[2*j+1] = q_rdata[j][15:8];
      end
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_byte_nxt = bytes_r[pos_r];
        out_last_nxt = (pos_r == LAST_POS);
        pos_nxt      = pos_r + POS_W'(1);
        if (pos_r == LAST_POS) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (q_pop) begin
      pos_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r    <= bytes_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  `CFB_ASSERT_IMP(a_last_ends_frame, out_valid_r && out_last_r,
                  !busy_r || pos_r == '0, "last byte sent with frame still open")

endmodule

@@ sim/crc16_command_frame_builder_tb.sv @@
// Self-checking testbench for the CRC-16 command frame builder.
`timescale 1ns / 100ps

module crc16_command_frame_builder_tb import crc16cfb_pkg::*; ();

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  // Predicts the 14-byte frame of each accepted command and checks the bytes in order.
  class frame_checker;
    frame_byte_t pending_bytes[$];
    logic [15:0] opcode_reg;
    logic [15:0] trailer_reg;
    int          mismatches;
    int          frames_noted;
    int          bytes_checked;

    function new();
      opcode_reg    = OPCODE_RESET;
      trailer_reg   = TRAILER_RESET;
      mismatches    = 0;
      frames_noted  = 0;
      bytes_checked = 0;
    endfunction

    function void write_reg(logic [0:0] index, logic [15:0] data);
      if (index == REG_OPCODE) begin
        opcode_reg = data;
      end else if (index == REG_TRAILER) begin
        trailer_reg = data;
      end
    endfunction

    // Bit-serial CRC over the leading words, MSB first, starting from zero.
    function logic [15:0] frame_crc(frame_t words);
      logic [15:0] crc;
      logic        carry;
      crc = '0;
      for (int k = 0; k < CRC_WORDS; k++) begin
        for (int b = 15; b >= 0; b--) begin
          carry = crc[15];
          crc   = {crc[14:0], words[k][b]};
          if (carry) begin
            crc = crc ^ CRC_POLY;
          end
        end
      end
      return crc;
    endfunction

    function void note_command(logic [15:0] node, logic [15:0] obj_index, logic [31:0] value);
      frame_t      words;
      frame_byte_t fb;
      words[0] = opcode_reg;
      words[1] = obj_index;
      words[2] = {node[7:0], node[15:8]};
      words[3] = value[15:0];
      words[4] = value[31:16];
      words[5] = '0;
      words[6] = trailer_reg;
      words[5] = frame_crc(words);
      // Word 0 goes out high byte first, every other word low byte first.
      for (int p = 0; p < FRAME_BYTES; p++) begin
        if (p < 2) begin
          fb.value = (p == 0) ? words[0][15:8] : words[0][7:0];
        end else begin
          fb.value = p[0] ? words[p / 2][15:8] : words[p / 2][7:0];
        end
        fb.last = (p == FRAME_BYTES - 1);
        pending_bytes.push_back(fb);
      end
      frames_noted++;
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      frame_byte_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                 $time, value, last);
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (value !== want.value) begin
        mismatches++;
        $display("%0t: frame byte mismatch, expected %02h, actual %02h",
                 $time, want.value, value);
      end
      if (last !== want.last) begin
        mismatches++;
        $display("%0t: last flag mismatch, expected %0b, actual %0b",
                 $time, want.last, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_OPCODE;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_node_id = '0;
  logic [15:0] in_object_index = '0;
  logic [31:0] in_data_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;

  frame_checker board = new();
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;
  bit           holding = 1'b0;
  int           settings_used = 0;

  crc16_command_frame_builder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_node_id     (in_node_id),
    .in_object_index(in_object_index),
    .in_data_value  (in_data_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: check each accepted byte, then stall in random bursts or one long hold.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        board.check_byte(out_frame_byte, out_last_byte);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 200;
      end else if (rst_n && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      holding = (stall_left > 0) && (stall_left > 12 || holding);
      out_stall <= (stall_left > 0);
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(logic [15:0] node, logic [15:0] obj_index, logic [31:0] value);
    in_valid        <= 1'b1;
    in_node_id      <= node;
    in_object_index <= obj_index;
    in_data_value   <= value;
    do @(posedge clk); while (in_stall);
    board.note_command(node, obj_index, value);
    // Keep valid up for back-to-back items; drop it only for a real gap.
    if (!calm && !holding && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] index, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(index, data);
  endtask

  task automatic set_regs(logic [15:0] opcode, logic [15:0] trailer);
    wait_drained();
    write_reg(REG_OPCODE, opcode);
    write_reg(REG_TRAILER, trailer);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings_used = 1;

    // Directed: field extremes and byte-swap patterns with the reset registers.
    send_command(16'h0000, 16'h0000, 32'h0000_0000);
    send_command(16'hffff, 16'hffff, 32'hffff_ffff);
    send_command(16'h00ff, 16'hff00, 32'h0000_ffff);
    send_command(16'hff00, 16'h00ff, 32'hffff_0000);
    send_command(16'h5555, 16'haaaa, 32'h5555_5555);
    send_command(16'haaaa, 16'h5555, 32'haaaa_aaaa);
    send_command(16'h0001, 16'h8000, 32'h8000_0000);
    send_command(16'h8000, 16'h0001, 32'h0000_0001);
    send_command(16'h1234, 16'h6081, 32'hdead_beef);
    send_command(16'h0102, 16'h607a, 32'h0001_0000);

    // Directed: register extremes.
    set_regs(16'h0000, 16'hffff);
    send_command(16'h0000, 16'h0000, 32'h0000_0000);
    send_command(16'hffff, 16'hffff, 32'hffff_ffff);
    send_command(16'h00ff, 16'h8000, 32'h0000_8000);
    set_regs(16'hffff, 16'h0000);
    send_command(16'h0000, 16'h0000, 32'h0000_0000);
    send_command(16'hffff, 16'hffff, 32'hffff_ffff);
    send_command(16'hff00, 16'h0001, 32'h8000_0001);
    set_regs(16'h8000, 16'h0001);
    send_command(16'h0000, 16'h0000, 32'h0000_0000);
    send_command(16'h7fff, 16'hfffe, 32'h7fff_ffff);

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_regs(OPCODE_RESET, TRAILER_RESET);
        4:       set_regs(16'hffff, 16'hffff);
        default: set_regs(pick16(), pick16());
      endcase
      if (phase == 4) begin
        calm = 1'b1;
      end
      for (int n = 0; n < 42; n++) begin
        if (phase == 1 && n == 8) begin
          hold_req = 1'b1;
        end
        send_command(pick16(), pick16(), pick32());
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (board.pending_bytes.size() != 0) begin
      board.mismatches += board.pending_bytes.size();
      $display("%0t: %0d frame bytes never arrived", $time, board.pending_bytes.size());
    end
    $display("Sent %0d commands under %0d register settings, checked %0d frame bytes",
             board.frames_noted, settings_used, board.bytes_checked);
    $display("Included one long receiver hold-off and a final stretch with no idling");
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
